[design/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the postfix expression evaluator
// Stack sizing, character codes, result status codes, controller states and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } pfe_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_POP,
    S_FIN
  } pfe_state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic div_load;
    logic pop_load;
    logic finish;
  } pfe_cmd_t;

  typedef struct packed {
    logic need_read;
    logic in_last;
    logic div_run;
    logic need_pop;
    logic div_done;
    logic last;
    logic out_free;
  } pfe_stat_t;

endpackage

`default_nettype wire

[design/pfe_div.sv]
// ----------------------------------------------------------------------------
// pfe_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done_o pulses for one cycle
// when the quotient is ready and the quotient then holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div
  import pfe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quotient_o
);

  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DATA_W:0]      trial;

  always_comb begin
    trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, den_q};
    if (!trial[DATA_W]) begin
      rem_d = trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
      quo_d = {quo_q[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[design/pfe_dp.sv]
// ----------------------------------------------------------------------------
// pfe_dp: evaluator datapath
// Top of stack in a register, the entries below it in a memory, the ALU, the
// divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_dp
  import pfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pfe_cmd_t    cmd_i,
  output pfe_stat_t        stat_o,
  input  wire logic [7:0]  in_symbol_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [DATA_W-1:0] out_value_o,
  output logic [2:0]       out_status_o
);

  logic [DATA_W-1:0] stack_mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  pfe_status_e       err_q, err_d;
  logic [7:0]        sym_q;
  logic              last_q;
  logic              negq_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  pfe_status_e       out_status_q;

  logic              in_digit;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;
  logic [DATA_W-1:0] left, right;
  logic [DATA_W-1:0] dividend_abs, divisor_abs;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] quotient;
  logic              out_free;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);
  assign cnt_m3 = cnt_q - CNT_W'(3);
  assign left   = rdata_q;
  assign right  = top_q;

  assign in_digit = in_symbol_i inside {[SYM_ZERO:SYM_NINE]};

  // The entries below the top live in memory: logical entry k is stored at k.
  assign we    = cmd_i.accept && (err_q == ST_OK) && in_digit &&
                 (cnt_q != CNT_W'(STACK_DEPTH)) && (cnt_q != '0);
  assign waddr = cnt_m1[IDX_W-1:0];
  assign raddr = cmd_i.exec ? cnt_m3[IDX_W-1:0] : cnt_m2[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem_q[waddr] <= top_q;
    end
    rdata_q <= stack_mem_q[raddr];
  end

  assign dividend_abs = left[DATA_W-1]  ? (DATA_W'(0) - left)  : left;
  assign divisor_abs  = right[DATA_W-1] ? (DATA_W'(0) - right) : right;
  assign div_start    = cmd_i.exec && (sym_q == SYM_DIV) && (right != '0);

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_abs),
    .divisor_i  (divisor_abs),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    top_d = top_q;
    cnt_d = cnt_q;
    err_d = err_q;
    if (cmd_i.accept && (err_q == ST_OK)) begin
      if (in_digit) begin
        if (cnt_q == CNT_W'(STACK_DEPTH)) begin
          err_d = ST_OVERFLOW;
        end else begin
          top_d = {{(DATA_W-8){1'b0}}, in_symbol_i - SYM_ZERO};
          cnt_d = cnt_q + CNT_W'(1);
        end
      end else if (cnt_q < CNT_W'(2)) begin
        err_d = ST_UNDERFLOW;
      end
    end
    if (cmd_i.exec) begin
      case (sym_q)
        SYM_ADD: begin
          top_d = left + right;
          cnt_d = cnt_m1;
        end
        SYM_SUB: begin
          top_d = left - right;
          cnt_d = cnt_m1;
        end
        SYM_MUL: begin
          top_d = left * right;
          cnt_d = cnt_m1;
        end
        SYM_DIV: begin
          if (right == '0) begin
            err_d = ST_DIVZERO;
            cnt_d = cnt_m2;
          end
        end
        default: begin
          // Any other symbol drops both operands; the new top is fetched later.
          cnt_d = cnt_m2;
        end
      endcase
    end
    if (cmd_i.div_load) begin
      top_d = negq_q ? (DATA_W'(0) - quotient) : quotient;
      cnt_d = cnt_m1;
    end
    if (cmd_i.pop_load) begin
      top_d = rdata_q;
    end
    if (cmd_i.finish) begin
      cnt_d = '0;
      err_d = ST_OK;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (cmd_i.accept) begin
        last_q <= in_last_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.accept) begin
      sym_q <= in_symbol_i;
    end
    if (div_start) begin
      negq_q <= left[DATA_W-1] ^ right[DATA_W-1];
    end
    if (cmd_i.finish) begin
      if (err_q != ST_OK) begin
        out_value_q  <= '0;
        out_status_q <= err_q;
      end else if (cnt_q == '0) begin
        out_value_q  <= '0;
        out_status_q <= ST_EMPTY;
      end else begin
        out_value_q  <= top_q;
        out_status_q <= ST_OK;
      end
    end
  end

  always_comb begin
    stat_o.need_read = (err_q == ST_OK) && !in_digit && (cnt_q >= CNT_W'(2));
    stat_o.in_last   = in_last_i;
    stat_o.div_run   = div_start;
    stat_o.need_pop  = !((sym_q == SYM_ADD) || (sym_q == SYM_SUB) ||
                         (sym_q == SYM_MUL) || (sym_q == SYM_DIV)) &&
                       (cnt_q > CNT_W'(2));
    stat_o.div_done  = div_done;
    stat_o.last      = last_q;
    stat_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

[design/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// pfe_ctrl: evaluator controller
// Sequences each item through operand read, arithmetic or division, top
// reload and the end-of-expression result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl
  import pfe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pfe_stat_t stat_i,
  output pfe_cmd_t       cmd_o
);

  pfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.need_read) begin
            state_d = S_READ;
          end else if (stat_i.in_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_READ: begin
        cmd_o.exec = 1'b1;
        if (stat_i.div_run) begin
          state_d = S_DIV;
        end else if (stat_i.need_pop) begin
          state_d = S_POP;
        end else begin
          state_d = stat_i.last ? S_FIN : S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_load = 1'b1;
          state_d = stat_i.last ? S_FIN : S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d = stat_i.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix expression evaluator
// Evaluates postfix expressions character by character on an operand stack.
// ----------------------------------------------------------------------------
// The input channel carries one character per item with a flag on the final
// character of an expression. Digits push, the four operators combine the two
// top entries, and any other character drops them. The output channel gives
// one item per expression: the top value and a status code.
// A digit, or any item after an error, is taken in from the idle state alone.
// An add, subtract or multiply also passes the read state, which uses the
// registered read of the left operand from the stack memory; a character
// that drops two operands then reloads the new top if entries remain. A
// division passes the operand read, 32 steps of the one-bit restoring
// divider and the quotient load; a final character loads the output register.
// in_stall_o is high while an item is being worked on. A finished result may
// wait in the output register while the next expression is taken in; only the
// next result waits for out_stall_i to fall. Reset empties the stack, clears
// the latched error and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator
  import pfe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          in_symbol_i,
  input  wire logic                in_last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [2:0]               out_status_o
);

  pfe_cmd_t          cmd;
  pfe_stat_t         stat;
  logic [DATA_W-1:0] value;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_symbol_i  (in_symbol_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (value),
    .out_status_o (out_status_o)
  );

  assign out_value_o = $signed(value);

endmodule

`default_nettype wire

[design/pfe_chk.sv]
// ----------------------------------------------------------------------------
// pfe_chk: port checker for the postfix expression evaluator
// Checks the result channel for held items and consistent value and status.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_chk
  import pfe_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic signed [DATA_W-1:0] out_value_o,
  input wire logic [2:0]          out_status_o
);

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_value_o) && $stable(out_status_o))
    else $error("result payload changed while stalled");

  // Any result with a status other than ST_OK reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_OK) |-> out_value_o == '0)
    else $error("non-zero value with an error status");

  // Only the five defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == ST_OK) || (out_status_o == ST_UNDERFLOW) ||
                    (out_status_o == ST_DIVZERO) || (out_status_o == ST_EMPTY) ||
                    (out_status_o == ST_OVERFLOW))
    else $error("undefined status code");

endmodule

bind postfix_expression_evaluator pfe_chk u_pfe_chk (.*);

`default_nettype wire
